/* rtl/dffp_pkg.sv */
// Shared constants and types of the delimited frame field parser.
package dffp_pkg;

  localparam int MAX_FIELDS_DEF    = 8;
  localparam int MAX_FIELD_LEN_DEF = 16;

  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 3;
  localparam int TYPE_W  = 7;
  localparam int CNT_W   = 4;
  localparam int LENO_W  = 5;
  localparam int VAL_W   = 16;

  localparam logic [BYTE_W-1:0] CH_START = 8'h73;  // 's'
  localparam logic [BYTE_W-1:0] CH_END   = 8'h65;  // 'e'
  localparam logic [BYTE_W-1:0] CH_SEP   = 8'h2c;  // ','
  localparam logic [BYTE_W-1:0] CH_P     = 8'h70;  // 'p'
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [BYTE_W-1:0] CH_SIX   = 8'h36;  // '6'
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;  // '9'

  localparam logic [TYPE_W-1:0] TYPE_P = 7'd112;

  typedef enum logic {
    ACT_RX   = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

/* rtl/delimited_frame_field_parser.sv */
// A received byte gives its result in the output register in the cycle after acceptance.
// A field read makes one store read ahead, then takes one digit per cycle through the
// multiply-by-ten accumulator, up to a non-digit or the end; bad indexes and empty fields are
// answered from the idle state. Throughput: one byte per cycle while the output is not stalled;
// a read stalls the input until it ends. Reset (synchronous, rst_n low) clears control, counts
// and field lengths; the byte store is not cleared, so the block is ready straight after reset.
module delimited_frame_field_parser
  import dffp_pkg::*;
#(
  parameter int MAX_FIELDS    = MAX_FIELDS_DEF,
  parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic [IDX_W-1:0]  in_field_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_frame_done,
  output logic              out_type_seen,
  output logic [TYPE_W-1:0] out_frame_type,
  output logic [CNT_W-1:0]  out_field_count,
  output logic [LENO_W-1:0] out_last_field_len,
  output logic [VAL_W-1:0]  out_field_value,
  output logic              out_value_is_char,
  output logic              out_index_ok
);

  localparam int FW    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int PW    = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1;
  localparam int LW    = $clog2(MAX_FIELD_LEN + 1);
  localparam int CW    = $clog2(MAX_FIELDS + 1);
  localparam int AW    = 1 + FW + PW;
  localparam int CMP_W = 8;

  state_t            st_r, st_nxt;
  logic              bank_r, bank_nxt;
  logic              receiving_r, receiving_nxt;
  logic              type_pend_r, type_pend_nxt;
  logic [TYPE_W-1:0] type_code_r, type_code_nxt;
  logic [FW-1:0]     cf_r, cf_nxt;
  logic [LW-1:0]     cur_len_r, cur_len_nxt;
  logic [CW-1:0]     frame_fields_r, frame_fields_nxt;
  logic [LW-1:0]     flast_r, flast_nxt;
  logic [LW-1:0]     rlen_r [MAX_FIELDS];
  logic [LW-1:0]     rlen_nxt [MAX_FIELDS];
  logic [LW-1:0]     flen_r [MAX_FIELDS];
  logic [LW-1:0]     flen_nxt [MAX_FIELDS];

  logic [FW-1:0]     rd_field_r, rd_field_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     ipos_r, ipos_nxt;
  logic [LW-1:0]     cpos_r, cpos_nxt;
  logic              rv_r, rv_nxt;
  logic [VAL_W-1:0]  sum_r, sum_nxt;

  logic              out_valid_r;
  logic              o_done_r, o_seen_r, o_char_r, o_ok_r;
  logic [TYPE_W-1:0] o_type_r;
  logic [CNT_W-1:0]  o_cnt_r;
  logic [LENO_W-1:0] o_len_r;
  logic [VAL_W-1:0]  o_val_r;

  logic              ld_out, o_done, o_seen, o_char, o_ok;
  logic [VAL_W-1:0]  o_val;

  logic              accept;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [CMP_W-1:0]  idx_x;
  logic [FW-1:0]     idx_f;
  logic              non_digit, last_digit;
  logic [VAL_W-1:0]  sum_x10;

  assign in_stall = (st_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign idx_x = CMP_W'(in_field_index);
  assign idx_f = idx_x[FW-1:0];

  // The receive bank is the one selected by bank_r; the last completed frame sits in the other.
  assign wr_addr = {bank_r, cf_r, cur_len_r[PW-1:0]};
  assign rd_addr = {~bank_r, rd_field_r, ipos_r[PW-1:0]};
  assign rd_en   = (st_r == ST_RUN) && (ipos_r < len_r);

  assign non_digit  = (rd_data < CH_ZERO) || (rd_data > CH_NINE);
  assign last_digit = (cpos_r + LW'(1)) == len_r;
  assign sum_x10    = (sum_r << 3) + (sum_r << 1);

  always_comb begin
    st_nxt           = st_r;
    bank_nxt         = bank_r;
    receiving_nxt    = receiving_r;
    type_pend_nxt    = type_pend_r;
    type_code_nxt    = type_code_r;
    cf_nxt           = cf_r;
    cur_len_nxt      = cur_len_r;
    frame_fields_nxt = frame_fields_r;
    flast_nxt        = flast_r;
    rlen_nxt         = rlen_r;
    flen_nxt         = flen_r;
    rd_field_nxt     = rd_field_r;
    len_nxt          = len_r;
    ipos_nxt         = ipos_r;
    cpos_nxt         = cpos_r;
    rv_nxt           = 1'b0;
    sum_nxt          = sum_r;
    wr_en            = 1'b0;
    ld_out           = 1'b0;
    o_done           = 1'b0;
    o_seen           = 1'b0;
    o_char           = 1'b0;
    o_ok             = 1'b0;
    o_val            = '0;

    unique case (st_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_RX)) begin
          ld_out = 1'b1;
          unique case (in_rx_byte)
            CH_START: begin
              receiving_nxt = 1'b1;
              type_pend_nxt = 1'b1;
              cf_nxt        = '0;
              cur_len_nxt   = '0;
            end
            CH_END: begin
              for (int i = 0; i < MAX_FIELDS; i++) begin
                flen_nxt[i] = (FW'(i) == cf_r) ? cur_len_r : rlen_r[i];
                rlen_nxt[i] = '0;
              end
              frame_fields_nxt = CW'(cf_r) + CW'(1);
              flast_nxt        = cur_len_r;
              bank_nxt         = ~bank_r;
              receiving_nxt    = 1'b0;
              cf_nxt           = '0;
              cur_len_nxt      = '0;
              o_done           = 1'b1;
            end
            CH_SEP: begin
              rlen_nxt[cf_r] = cur_len_r;
              if (cf_r != FW'(MAX_FIELDS - 1)) begin
                cf_nxt = cf_r + FW'(1);
              end
              cur_len_nxt = '0;
            end
            default: begin
              if (type_pend_r) begin
                if ((in_rx_byte >= CH_ONE) && (in_rx_byte <= CH_SIX)) begin
                  type_code_nxt = TYPE_W'(in_rx_byte - CH_ZERO);
                end else if (in_rx_byte == CH_P) begin
                  type_code_nxt = TYPE_P;
                end
                type_pend_nxt = 1'b0;
                o_seen        = 1'b1;
              end
              if (receiving_r && (cur_len_r < LW'(MAX_FIELD_LEN))) begin
                wr_en       = 1'b1;
                cur_len_nxt = cur_len_r + LW'(1);
              end
            end
          endcase
        end else if (accept) begin
          if ((idx_x >= CMP_W'(frame_fields_r)) || (idx_x >= CMP_W'(MAX_FIELDS))) begin
            ld_out = 1'b1;
          end else if (flen_r[idx_f] == '0) begin
            // An empty field reads as zero.
            ld_out = 1'b1;
            o_ok   = 1'b1;
          end else begin
            st_nxt       = ST_RUN;
            rd_field_nxt = idx_f;
            len_nxt      = flen_r[idx_f];
            ipos_nxt     = '0;
            cpos_nxt     = '0;
            sum_nxt      = '0;
          end
        end
      end
      ST_RUN: begin
        if (rd_en) begin
          ipos_nxt = ipos_r + LW'(1);
        end
        rv_nxt = rd_en;
        if (rv_r) begin
          cpos_nxt = cpos_r + LW'(1);
          sum_nxt  = sum_x10 + VAL_W'(rd_data - CH_ZERO);
          if (non_digit || last_digit) begin
            st_nxt = ST_IDLE;
            rv_nxt = 1'b0;
            ld_out = 1'b1;
            o_ok   = 1'b1;
            o_char = non_digit;
            o_val  = non_digit ? VAL_W'(rd_data) : sum_nxt;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      bank_r         <= 1'b0;
      receiving_r    <= 1'b0;
      type_pend_r    <= 1'b0;
      type_code_r    <= '0;
      cf_r           <= '0;
      cur_len_r      <= '0;
      frame_fields_r <= '0;
      flast_r        <= '0;
      rv_r           <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < MAX_FIELDS; i++) begin
        rlen_r[i] <= '0;
        flen_r[i] <= '0;
      end
    end else begin
      st_r           <= st_nxt;
      bank_r         <= bank_nxt;
      receiving_r    <= receiving_nxt;
      type_pend_r    <= type_pend_nxt;
      type_code_r    <= type_code_nxt;
      cf_r           <= cf_nxt;
      cur_len_r      <= cur_len_nxt;
      frame_fields_r <= frame_fields_nxt;
      flast_r        <= flast_nxt;
      rv_r           <= rv_nxt;
      rlen_r         <= rlen_nxt;
      flen_r         <= flen_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_field_r <= rd_field_nxt;
    len_r      <= len_nxt;
    ipos_r     <= ipos_nxt;
    cpos_r     <= cpos_nxt;
    sum_r      <= sum_nxt;
    if (ld_out) begin
      o_done_r <= o_done;
      o_seen_r <= o_seen;
      o_type_r <= type_code_nxt;
      o_cnt_r  <= CNT_W'(frame_fields_nxt);
      o_len_r  <= LENO_W'(flast_nxt);
      o_val_r  <= o_val;
      o_char_r <= o_char;
      o_ok_r   <= o_ok;
    end
  end

  dffp_field_store #(
    .AW(AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_rx_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_valid          = out_valid_r;
  assign out_frame_done     = o_done_r;
  assign out_type_seen      = o_seen_r;
  assign out_frame_type     = o_type_r;
  assign out_field_count    = o_cnt_r;
  assign out_last_field_len = o_len_r;
  assign out_field_value    = o_val_r;
  assign out_value_is_char  = o_char_r;
  assign out_index_ok       = o_ok_r;

`ifndef ASSERT_OFF
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> in_stall)
    else $error("input not stalled during a field read");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_len_r <= LW'(MAX_FIELD_LEN))
    else $error("open field length beyond its limit");

  a_issue_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> ((ipos_r >= cpos_r) && (ipos_r <= len_r)))
    else $error("store read pointer out of step with the digit pointer");

  a_char_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value_is_char) |-> out_index_ok)
    else $error("character result without a valid index");

  a_done_not_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (!out_type_seen && !out_index_ok))
    else $error("end marker item flagged as type check or read");
`endif

endmodule

/* rtl/dffp_field_store.sv */
// Byte store for the receive and frame banks, one write and one registered read port.
module dffp_field_store
  import dffp_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [2**AW];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* test/delimited_frame_field_parser_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the delimited frame field parser: framed byte traffic and field reads.
module delimited_frame_field_parser_tb;
  import dffp_pkg::*;

  localparam int NF          = MAX_FIELDS_DEF;
  localparam int FL          = MAX_FIELD_LEN_DEF;
  localparam int ITEM_TARGET = 900;
  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    action_t           act;
    logic [BYTE_W-1:0] rx;
    logic [IDX_W-1:0]  idx;
    int                gap;
    bit                hold_out;
    bit                drain;
  } parser_item_t;

  typedef struct packed {
    logic              done;
    logic              seen;
    logic [TYPE_W-1:0] ftype;
    logic [CNT_W-1:0]  count;
    logic [LENO_W-1:0] last_len;
    logic [VAL_W-1:0]  value;
    logic              is_char;
    logic              ok;
  } parse_result_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_action      = 1'b0;
  logic [BYTE_W-1:0] in_rx_byte     = '0;
  logic [IDX_W-1:0]  in_field_index = '0;
  logic              out_valid;
  logic              out_stall      = 1'b1;
  logic              out_frame_done;
  logic              out_type_seen;
  logic [TYPE_W-1:0] out_frame_type;
  logic [CNT_W-1:0]  out_field_count;
  logic [LENO_W-1:0] out_last_field_len;
  logic [VAL_W-1:0]  out_field_value;
  logic              out_value_is_char;
  logic              out_index_ok;

  delimited_frame_field_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_rx_byte        (in_rx_byte),
    .in_field_index    (in_field_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_done    (out_frame_done),
    .out_type_seen     (out_type_seen),
    .out_frame_type    (out_frame_type),
    .out_field_count   (out_field_count),
    .out_last_field_len(out_last_field_len),
    .out_field_value   (out_field_value),
    .out_value_is_char (out_value_is_char),
    .out_index_ok      (out_index_ok)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the parser state.
  logic [BYTE_W-1:0] rx_bytes  [NF][FL];
  logic [BYTE_W-1:0] frm_bytes [NF][FL];
  logic [LENO_W-1:0] rx_len    [NF];
  logic [LENO_W-1:0] frm_len   [NF];
  bit                receiving;
  bit                type_pending;
  logic [TYPE_W-1:0] type_code      = '0;
  int                cur_field      = 0;
  int                cur_len        = 0;
  logic [CNT_W-1:0]  frame_fields   = '0;
  logic [LENO_W-1:0] frame_last_len = '0;

  parser_item_t  pend_q[$];
  parse_result_t exp_q[$];
  int            mismatch_count = 0;
  bit            send_calm;
  bit            next_hold;
  bit            next_drain;
  bit            in_taken;
  bit            hold_req;
  bit            rcv_calm;
  int            rcv_wait  = -1;
  int            hold_left = 0;
  parser_item_t  cur;
  bit            have_cur;
  int            gap_left;

  function automatic parse_result_t parse_step(input parser_item_t it);
    parse_result_t     r;
    logic [BYTE_W-1:0] c;
    logic [VAL_W-1:0]  acc;
    int                len;
    int                i;
    r = '0;
    if (it.act == ACT_RX) begin
      if (it.rx == CH_START) begin
        receiving    = 1'b1;
        type_pending = 1'b1;
        cur_field    = 0;
        cur_len      = 0;
      end else if (it.rx == CH_END) begin
        rx_len[cur_field] = LENO_W'(cur_len);
        frame_fields      = CNT_W'(cur_field + 1);
        frame_last_len    = LENO_W'(cur_len);
        frm_bytes         = rx_bytes;
        frm_len           = rx_len;
        // Stale bytes may stay in the receive store, as no length covers them again.
        foreach (rx_len[f]) rx_len[f] = '0;
        receiving = 1'b0;
        cur_field = 0;
        cur_len   = 0;
        r.done    = 1'b1;
      end else if (it.rx == CH_SEP) begin
        rx_len[cur_field] = LENO_W'(cur_len);
        // The last field soaks up extra separators and starts over each time.
        if (cur_field < NF - 1) cur_field++;
        cur_len = 0;
      end else begin
        if (type_pending) begin
          if (it.rx >= CH_ONE && it.rx <= CH_SIX) type_code = TYPE_W'(it.rx - CH_ZERO);
          else if (it.rx == CH_P) type_code = TYPE_P;
          type_pending = 1'b0;
          r.seen       = 1'b1;
        end
        if (receiving && cur_len < FL) begin
          rx_bytes[cur_field][cur_len] = it.rx;
          cur_len++;
        end
      end
    end else if (it.idx < frame_fields) begin
      r.ok = 1'b1;
      acc  = '0;
      len  = frm_len[it.idx];
      for (i = 0; i < len && !r.is_char; i++) begin
        c = frm_bytes[it.idx][i];
        if (c < CH_ZERO || c > CH_NINE) begin
          r.value   = c;
          r.is_char = 1'b1;
        end else begin
          acc = VAL_W'(acc * 10 + (c - CH_ZERO));
        end
      end
      if (!r.is_char) r.value = acc;
    end
    r.ftype    = type_code;
    r.count    = frame_fields;
    r.last_len = frame_last_len;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                      input logic [VAL_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic queue_item(input action_t act, input logic [BYTE_W-1:0] b,
                            input logic [IDX_W-1:0] i);
    parser_item_t it;
    it.act      = act;
    it.rx       = b;
    it.idx      = i;
    it.gap      = send_calm ? 0 : $urandom_range(0, 5);
    it.hold_out = next_hold;
    it.drain    = next_drain;
    next_hold   = 1'b0;
    next_drain  = 1'b0;
    pend_q.push_back(it);
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    queue_item(ACT_RX, b, IDX_W'($urandom));
  endtask

  task automatic queue_read(input logic [IDX_W-1:0] i);
    queue_item(ACT_READ, BYTE_W'($urandom), i);
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255));
    while (b == CH_START || b == CH_END || b == CH_SEP);
    return b;
  endfunction

  // Mostly well-formed frames with digit fields; some are left open or followed by noise.
  task automatic queue_frame();
    int                nfields;
    int                len;
    int                f;
    int                k;
    bit                broken;
    logic [BYTE_W-1:0] b;
    nfields = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 11) : $urandom_range(1, 4);
    broken  = ($urandom_range(0, 9) == 0);
    queue_byte(CH_START);
    for (f = 0; f < nfields; f++) begin
      if (f > 0) queue_byte(CH_SEP);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 5);
      for (k = 0; k < len; k++) begin
        if (f == 0 && k == 0) begin
          case ($urandom_range(0, 4))
            0, 1:    b = BYTE_W'(CH_ONE + $urandom_range(0, 5));
            2:       b = CH_P;
            3:       b = BYTE_W'(CH_ZERO + $urandom_range(0, 9));
            default: b = plain_byte();
          endcase
        end else if ($urandom_range(0, 15) == 0) begin
          b = plain_byte();
        end else begin
          b = BYTE_W'(CH_ZERO + $urandom_range(0, 9));
        end
        queue_byte(b);
      end
    end
    if (!broken) queue_byte(CH_END);
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 4)) queue_byte(BYTE_W'($urandom));
    end
    repeat ($urandom_range(1, 3)) queue_read(IDX_W'($urandom_range(0, 7)));
  endtask

  // Result checking and prediction on accepted items.
  always @(posedge clk) begin
    parse_result_t want;
    parser_item_t  it;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        rcv_wait = -1;
        if ($urandom_range(0, 39) == 0) rcv_calm = !rcv_calm;
        if (exp_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, expected nothing, got value %0d",
                   $time, out_field_value);
        end else begin
          want = exp_q.pop_front();
          check_field("frame_done",     want.done,     out_frame_done);
          check_field("type_seen",      want.seen,     out_type_seen);
          check_field("frame_type",     want.ftype,    out_frame_type);
          check_field("field_count",    want.count,    out_field_count);
          check_field("last_field_len", want.last_len, out_last_field_len);
          check_field("field_value",    want.value,    out_field_value);
          check_field("value_is_char",  want.is_char,  out_value_is_char);
          check_field("index_ok",       want.ok,       out_index_ok);
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        it.act = action_t'(in_action);
        it.rx  = in_rx_byte;
        it.idx = in_field_index;
        exp_q.push_back(parse_step(it));
      end
    end
  end

  // Sender: holds a stalled item, else waits out its gap and any result drain, then offers it.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (!have_cur && pend_q.size() > 0) begin
        cur      = pend_q.pop_front();
        have_cur = 1'b1;
        gap_left = cur.gap;
      end
      if (!have_cur) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cur.drain && exp_q.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid       <= 1'b1;
        in_action      <= cur.act;
        in_rx_byte     <= cur.rx;
        in_field_index <= cur.idx;
        if (cur.hold_out) hold_req = 1'b1;
        have_cur = 1'b0;
      end
    end
  end

  // Receiver: a random wait per result, calm stretches, and one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_valid) begin
      if (rcv_wait < 0) rcv_wait = rcv_calm ? 0 : $urandom_range(0, 5);
      if (rcv_wait > 0) begin
        rcv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= 1'($urandom_range(0, 1));
    end
  end

  initial begin
    int frame_no;
    foreach (rx_len[f]) begin
      rx_len[f]  = '0;
      frm_len[f] = '0;
    end

    // Bad indexes, a separator with no frame, non-digit fields, empty fields and the
    // type check surviving an empty frame.
    queue_read(IDX_W'(7));
    queue_byte(CH_SEP);
    queue_byte(CH_START); queue_byte(8'hFF); queue_byte(CH_END);
    queue_read(IDX_W'(0));
    queue_byte(CH_START); queue_byte(CH_END);
    queue_byte(8'h00);
    queue_byte(CH_START); queue_byte(CH_ZERO + 8'd4); queue_byte(CH_ZERO + 8'd2);
    queue_byte(CH_SEP); queue_byte(CH_SEP);
    queue_byte(CH_NINE); queue_byte(CH_ZERO); queue_byte(CH_END);
    queue_read(IDX_W'(0)); queue_read(IDX_W'(1)); queue_read(IDX_W'(2));
    queue_read(IDX_W'(3));
    queue_byte(CH_START); queue_byte(CH_P); queue_byte(CH_END);
    queue_read(IDX_W'(0));

    frame_no = 0;
    while (pend_q.size() < ITEM_TARGET) begin
      send_calm  = (frame_no >= 8 && frame_no <= 10) || ($urandom_range(0, 5) == 0);
      next_hold  = (frame_no == 8);
      next_drain = (frame_no == 15) || ($urandom_range(0, 29) == 0);
      queue_frame();
      frame_no++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || have_cur || in_valid) @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
rtl/dffp_pkg.sv
rtl/dffp_field_store.sv
rtl/delimited_frame_field_parser.sv
test/delimited_frame_field_parser_tb.sv
